// File: hw/rtl/dis_pkg.sv
package dis_pkg;

  // capacity of the record store
  localparam int MAX_ENTRIES = 16;

  // field widths
  localparam int KEY_W   = 16;
  localparam int TAG_W   = 8;
  localparam int ENTRY_W = KEY_W + TAG_W;

  // stream data width, padded up to whole bytes
  localparam int TDATA_W = ((ENTRY_W + 7) / 8) * 8;

  // store addressing and fill count
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_ERD,
    ST_EOUT
  } state_t;

endpackage

// File: hw/rtl/descending_insertion_sort_records.sv
// Stable descending insertion sort of tagged records.
// Input channel in_*: one record per item, key and tag in in_tdata, in_tlast
// marks the last record of a set. Output channel out_*: on a set end, every
// stored record is sent in descending key order, the final one with
// out_tlast high; out_tuser is high on all items of a run in which records
// were dropped because the store was full.
// Records sit in one single-port-write, registered-read memory. An insertion
// walks from the end of the table toward its head, one read and one write
// per step; each stored record that moves takes one such step.
// Emission reads one record per step; a full output register stalls the
// walk until out_tready takes its item.
// The output register decouples the two sides: a new input item can be
// accepted while the last record of a run still waits on out_tready.
// Reset (rst_n low, synchronous) empties the store and clears the drop flag
// and out_tvalid; the memory itself is not cleared.
module descending_insertion_sort_records (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: temperature [15:0], record_tag [23:16]
  input  logic [dis_pkg::TDATA_W-1:0] in_tdata,
  input  logic                        in_tlast,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // out_tdata: sorted_temperature [15:0], sorted_tag [23:16]
  output logic [dis_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  // out_tuser: overflow [0]
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready
);
  import dis_pkg::*;

  // record store
  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

  // sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic               last_r, last_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               drop_r, drop_nxt;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_valid_r, out_valid_nxt;

  // memory port controls
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  // shared conditions
  logic in_acc;
  logic full;
  logic shift;
  logic out_free;
  logic idx_final;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(MAX_ENTRIES));
  assign shift     = $signed(rd_data_r[KEY_W-1:0]) < $signed(key_r);
  assign out_free  = !out_valid_r || out_tready;
  assign idx_final = ({1'b0, idx_r} + CNT_W'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!full) begin
            state_nxt = ST_SCAN;
          end else if (in_tlast) begin
            state_nxt = ST_ERD;
          end
        end
      end
      ST_SCAN: begin
        if (pos_r == '0) begin
          state_nxt = last_r ? ST_ERD : ST_IDLE;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (shift) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = last_r ? ST_ERD : ST_IDLE;
        end
      end
      ST_ERD: begin
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_free) begin
          state_nxt = idx_final ? ST_IDLE : ST_ERD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = {tag_r, key_r};
    rd_en         = 1'b0;
    rd_addr       = pos_r - ADDR_W'(1);
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          key_nxt  = in_tdata[KEY_W-1:0];
          tag_nxt  = in_tdata[ENTRY_W-1:KEY_W];
          last_nxt = in_tlast;
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            pos_nxt = count_r[ADDR_W-1:0];
          end
        end
      end
      ST_SCAN: begin
        if (pos_r == '0) begin
          // reached the head: place the new record
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_CMP: begin
        if (shift) begin
          // smaller key moves one place toward the end
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          pos_nxt = pos_r - ADDR_W'(1);
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_ERD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
      end
      ST_EOUT: begin
        if (out_free) begin
          out_data_nxt  = rd_data_r;
          out_last_nxt  = idx_final;
          out_ovf_nxt   = drop_r;
          out_valid_nxt = 1'b1;
          if (idx_final) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    tag_r      <= tag_nxt;
    last_r     <= last_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // memory read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // output channel
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;
  assign out_tvalid = out_valid_r;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dis_pkg::*;

  // quiet cycles tolerated before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;
  // settle time after the last result, one full insertion and then some
  localparam int TAIL_CYCLES    = 4 * MAX_ENTRIES + 4;
  // random items after the directed part
  localparam int RANDOM_ITEMS   = 354;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    last;
    logic                    ovf;
  } sorted_rec_t;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_t;
  typedef enum {KEY_FULL, KEY_FEW, KEY_EDGE, KEY_RISING, KEY_FALLING} key_style_t;

  logic               clk;
  logic               rst_n;
  logic [TDATA_W-1:0] in_tdata;
  logic               in_tlast;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;
  logic               out_tuser;
  logic               out_tvalid;
  logic               out_tready;

  // sorter state as predicted
  logic signed [KEY_W-1:0] held_key [MAX_ENTRIES];
  logic [TAG_W-1:0]        held_tag [MAX_ENTRIES];
  int                      held_count = 0;
  logic                    held_dropped = 1'b0;

  sorted_rec_t sorted_run_q[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          items_sent = 0;

  descending_insertion_sort_records uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // insert one record into the predicted table, emit the run on a set end
  task automatic insert_and_flush(input logic signed [KEY_W-1:0] key,
                                  input logic [TAG_W-1:0] tag, input logic set_end);
    int          pos;
    sorted_rec_t rec;
    if (held_count >= MAX_ENTRIES) begin
      held_dropped = 1'b1;
    end else begin
      // only strictly smaller keys move, so ties keep arrival order
      pos = held_count;
      while (pos > 0 && held_key[pos-1] < key) begin
        held_key[pos] = held_key[pos-1];
        held_tag[pos] = held_tag[pos-1];
        pos--;
      end
      held_key[pos] = key;
      held_tag[pos] = tag;
      held_count++;
    end
    if (set_end) begin
      for (int i = 0; i < held_count; i++) begin
        rec.key  = held_key[i];
        rec.tag  = held_tag[i];
        rec.last = (i == held_count - 1);
        rec.ovf  = held_dropped;
        sorted_run_q.push_back(rec);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  // send one record, opening a new burst after a random gap when due
  task automatic send_record(input logic signed [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag, input logic set_end);
    logic [TDATA_W-1:0] word;
    int                 gap;
    word = '0;
    word[KEY_W-1:0]    = key;
    word[KEY_W +: TAG_W] = tag;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= set_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    insert_and_flush(key, tag, set_end);
    items_sent++;
  endtask

  // hold the sender off until every predicted result has arrived
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (sorted_run_q.size() != 0) @(posedge clk);
  endtask

  // extreme keys and tags, with ties on the largest key
  task automatic test_extremes_and_ties();
    send_record(16'sd0, 8'h00, 1'b0);
    send_record(16'sd32767, 8'hFF, 1'b0);
    send_record(-16'sd32768, 8'h01, 1'b0);
    send_record(-16'sd1, 8'h80, 1'b0);
    send_record(16'sd32767, 8'h7F, 1'b0);
    send_record(16'sd1, 8'h02, 1'b0);
    send_record(-16'sd1, 8'h55, 1'b1);
    wait_for_drain();
  endtask

  // a set of one record gives a run of one
  task automatic test_single_record_set();
    send_record(-16'sd12345, 8'hA5, 1'b1);
    wait_for_drain();
  endtask

  // fill the store, drop a plain record, then drop the set end itself
  task automatic test_store_overflow();
    for (int i = 0; i <= MAX_ENTRIES; i++)
      send_record(KEY_W'((i % 3) * 100 - 100), TAG_W'(i), 1'b0);
    send_record(16'sd32767, 8'hEE, 1'b1);
    wait_for_drain();
  endtask

  // random sets, mostly within capacity, some exactly full or overflowing
  task automatic test_random_sets();
    int                      set_len;
    int                      pick;
    key_style_t              style;
    logic signed [KEY_W-1:0] key;
    while (items_sent < RANDOM_ITEMS + 26) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        set_len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
      else if (pick == 1)
        set_len = MAX_ENTRIES;
      else
        set_len = $urandom_range(1, MAX_ENTRIES - 1);
      style = key_style_t'($urandom_range(0, 4));
      for (int i = 0; i < set_len; i++) begin
        case (style)
          KEY_FULL:    key = KEY_W'($urandom);
          KEY_FEW:     key = KEY_W'(int'($urandom_range(0, 6)) - 3);
          KEY_EDGE: begin
            pick = $urandom_range(0, 3);
            key = (pick == 0) ? 16'sd32767 : (pick == 1) ? -16'sd32768 :
                  (pick == 2) ? 16'sd0 : -16'sd1;
          end
          KEY_RISING:  key = KEY_W'(i * 3000 - 30000 + int'($urandom_range(0, 2999)));
          default:     key = KEY_W'(30000 - i * 3000 - int'($urandom_range(0, 2999)));
        endcase
        send_record(key, TAG_W'($urandom_range(0, 255)), i == set_len - 1);
      end
      if ($urandom_range(0, 19) == 0)
        wait_for_drain();
    end
  endtask

  // receiver ready pattern, switching to a random mode after each random span
  initial begin : receiver_stall
    rx_mode_t mode;
    int       span;
    out_tready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      for (int phase = 0; phase < span; phase++) begin
        @(negedge clk);
        case (mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= (phase % 5 == 0);
        endcase
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    sorted_rec_t             want;
    logic signed [KEY_W-1:0] got_key;
    logic [TAG_W-1:0]        got_tag;
    if (rst_n && out_tvalid && out_tready) begin
      got_key = out_tdata[KEY_W-1:0];
      got_tag = out_tdata[KEY_W +: TAG_W];
      if (sorted_run_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: key %0d tag %0d last %0b ovf %0b",
                   got_key, got_tag, out_tlast, out_tuser);
      end else begin
        want = sorted_run_q.pop_front();
        if (got_key !== want.key || got_tag !== want.tag ||
            out_tlast !== want.last || out_tuser !== want.ovf) begin
          mismatches++;
          // fields in order: key tag last ovf
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                     want.key, want.tag, want.last, want.ovf,
                     got_key, got_tag, out_tlast, out_tuser);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // reset, tests in turn, then the verdict
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes_and_ties();
    test_single_record_set();
    test_store_overflow();
    test_random_sets();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && sorted_run_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
